// File: src/cyclic_code_systematic_encoder_macros.svh
// Assertion macros shared by the encoder RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef CYCLIC_CODE_SYSTEMATIC_ENCODER_MACROS_SVH
`define CYCLIC_CODE_SYSTEMATIC_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ccse_pkg.sv
// Shared types and constants of the cyclic code systematic encoder.
// No dependencies; used by ccse_cell and cyclic_code_systematic_encoder.
package ccse_pkg;

    // Field widths
    localparam int LEN_W     = 6;
    localparam int GEN_W     = 63;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_LEN   = 2'd1;

    // Register reset values
    localparam logic [GEN_W-1:0] GEN_RESET = 63'd209;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd8;

    // Per-cycle control broadcast to every remainder cell
    typedef struct packed {
        logic shift;   // advance the chain this cycle
        logic fb_en;   // apply generator feedback on this shift
        logic clr;     // drop the whole remainder
    } t_cell_ctrl;

endpackage

// File: src/cyclic_code_systematic_encoder.sv
// Top level of the bit-serial systematic cyclic code encoder.
// Depends on ccse_pkg, ccse_cell and cyclic_code_systematic_encoder_macros.svh.
//
// Message request (i_msg_valid/o_msg_ready): one bit per request, highest
// degree first, i_msg_last on the final bit. Each bit reaches the code channel
// in the cycle after acceptance; a message's bits go back to back unless stalled.
// Code channel (o_code_valid/i_code_ready): codeword bits with o_is_parity and
// o_word_last, from one output register that reloads when empty or drained.
// After the last message bit the chain runs parity_len zero shifts and then
// shifts out parity_len parity bits, one per cycle the receiver takes them;
// the message channel is held off meanwhile.
// Configuration (i_cfg_valid/o_cfg_ready, always ready): index 0 writes
// gen_poly_low, index 1 writes parity_len (saturated to MAX_PARITY); write
// only while the block is idle.
// Reset (synchronous, active low) clears the remainder and the output valid flag
// and restores the generator 0xD1 with parity_len 8.
// A stalled receiver holds the output bit and stops parity emission and
// message acceptance until the bit is taken; zero shifts run on regardless.
module cyclic_code_systematic_encoder #(
    parameter int MAX_PARITY = 63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ccse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccse_pkg::GEN_W-1:0]     i_cfg_data,
    input  logic                           i_msg_valid,
    output logic                           o_msg_ready,
    input  logic                           i_msg_bit,
    input  logic                           i_msg_last,
    output logic                           o_code_valid,
    input  logic                           i_code_ready,
    output logic                           o_code_bit,
    output logic                           o_is_parity,
    output logic                           o_word_last
);
    import ccse_pkg::*;

`include "cyclic_code_systematic_encoder_macros.svh"

    localparam int IW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PARITY);
    localparam logic [LEN_W-1:0] LEN_INIT = (LEN_RESET > MAX_LEN) ? MAX_LEN : LEN_RESET;
    localparam logic [LEN_W-1:0] CNT_ONE  = LEN_W'(1);

    localparam logic [1:0] ST_MSG  = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [MAX_PARITY-1:0] r_gen;
    logic [LEN_W-1:0]      r_len;
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [LEN_W-1:0]      r_cnt;
    logic [LEN_W-1:0]      n_cnt;
    logic                  r_out_valid;
    logic                  r_out_bit;
    logic                  r_out_parity;
    logic                  r_out_last;

    logic [MAX_PARITY-1:0] w_rem;
    logic [MAX_PARITY-1:0] w_prev;
    logic [IW-1:0]         w_top_idx;
    logic                  w_top;
    logic                  w_slot;
    logic                  w_msg_acc;
    logic                  w_in_bit;
    t_cell_ctrl            w_ctrl;
    logic                  w_out_load;
    logic                  w_new_bit;
    logic                  w_new_par;
    logic                  w_new_last;
    logic [LEN_W-1:0]      w_len_m1;
    logic                  w_last_acc;
    logic                  w_emit_end;
    logic                  w_out_final;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= GEN_RESET[MAX_PARITY-1:0];
            r_len <= LEN_INIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GEN_POLY_LOW: r_gen <= i_cfg_data[MAX_PARITY-1:0];
                REG_PARITY_LEN: begin
                    r_len <= (i_cfg_data[LEN_W-1:0] > MAX_LEN) ? MAX_LEN
                                                               : i_cfg_data[LEN_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Handshake on the message side
    assign w_slot      = !r_out_valid || i_code_ready;
    assign o_msg_ready = (r_state == ST_MSG) && w_slot;
    assign w_msg_acc   = i_msg_valid && o_msg_ready;

    // Select the top coefficient of the current degree
    assign w_len_m1  = r_len - CNT_ONE;
    assign w_top_idx = w_len_m1[IW-1:0];
    assign w_top     = (r_len != '0) && w_rem[w_top_idx];

    // Sequence message shifts, zero shifts and parity emission
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_ctrl     = '0;
        w_in_bit   = 1'b0;
        w_out_load = 1'b0;
        w_new_bit  = 1'b0;
        w_new_par  = 1'b0;
        w_new_last = 1'b0;
        unique case (r_state)
            ST_MSG: begin
                if (w_msg_acc) begin
                    w_ctrl.shift = 1'b1;
                    w_ctrl.fb_en = 1'b1;
                    w_in_bit     = i_msg_bit;
                    w_out_load   = 1'b1;
                    w_new_bit    = i_msg_bit;
                    w_new_last   = i_msg_last && (r_len == '0);
                    if (i_msg_last && (r_len != '0)) begin
                        n_state = ST_ZERO;
                        n_cnt   = r_len;
                    end
                end
            end
            ST_ZERO: begin
                w_ctrl.shift = 1'b1;
                w_ctrl.fb_en = 1'b1;
                if (r_cnt == CNT_ONE) begin
                    n_state = ST_EMIT;
                    n_cnt   = r_len;
                end else begin
                    n_cnt = r_cnt - CNT_ONE;
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    w_ctrl.shift = 1'b1;
                    w_out_load   = 1'b1;
                    w_new_bit    = w_top;
                    w_new_par    = 1'b1;
                    w_new_last   = (r_cnt == CNT_ONE);
                    n_cnt        = r_cnt - CNT_ONE;
                    if (r_cnt == CNT_ONE) begin
                        w_ctrl.clr = 1'b1;
                        n_state    = ST_MSG;
                    end
                end
            end
            default: begin
                n_state = ST_MSG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MSG;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Remainder chain: each cell takes its lower neighbor's bit
    for (genvar g = 0; g < MAX_PARITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = w_in_bit;
        end else begin : g_rest
            assign w_prev[g] = w_rem[g-1];
        end
        ccse_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_len   (r_len),
            .i_prev  (w_prev[g]),
            .i_top   (w_top),
            .i_gen   (r_gen[g]),
            .o_bit   (w_rem[g])
        );
    end

    // Output register: load a new bit or drain when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_code_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_bit    <= w_new_bit;
            r_out_parity <= w_new_par;
            r_out_last   <= w_new_last;
        end
    end

    assign o_code_valid = r_out_valid;
    assign o_code_bit   = r_out_bit;
    assign o_is_parity  = r_out_parity;
    assign o_word_last  = r_out_last;

    // Checks on sequencing
    assign w_last_acc  = w_msg_acc && i_msg_last && (r_len != '0);
    assign w_emit_end  = (r_state == ST_EMIT) && w_out_load && (r_cnt == CNT_ONE);
    assign w_out_final = o_code_valid && o_word_last && o_is_parity;

    `CCSE_ASSERT_NEXT(a_last_starts_zero, w_last_acc, r_state == ST_ZERO, "no zero shifts")
    `CCSE_ASSERT_NEXT(a_emit_end_clears, w_emit_end, w_rem == '0, "remainder not cleared")
    `CCSE_ASSERT_NEXT(a_emit_end_idle, w_emit_end, r_state == ST_MSG, "not back to message")
    `CCSE_ASSERT_SAME(a_zero_no_output, r_state == ST_ZERO, !w_out_load, "load in zero shifts")
    `CCSE_ASSERT_NEXT(a_final_parity_flag, w_emit_end, w_out_final, "final parity unflagged")

endmodule

// File: src/ccse_cell.sv
// One remainder cell of the encoder shift chain: holds one coefficient.
// Depends on ccse_pkg for the control struct and length width.
module ccse_cell #(
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ccse_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ccse_pkg::LEN_W-1:0] i_len,
    input  logic                       i_prev,
    input  logic                       i_top,
    input  logic                       i_gen,
    output logic                       o_bit
);
    import ccse_pkg::*;

    localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

    logic r_bit;
    logic n_bit;

    // Clear, or shift in neighbor bit with feedback; drop bits at or above the degree
    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.clr) begin
            n_bit = 1'b0;
        end else if (i_ctrl.shift) begin
            if (IDX_L < i_len) begin
                n_bit = i_prev ^ (i_top & i_gen & i_ctrl.fb_en);
            end else begin
                n_bit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: tb/sv/ccse_code_checker.sv
// Code channel checker for the cyclic code systematic encoder.
// Tracks register writes and message requests, predicts the codeword and
// compares every code request against it. Depends on ccse_pkg.
module ccse_code_checker #(
    parameter int MAX_PARITY = 63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ccse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccse_pkg::GEN_W-1:0]     i_cfg_data,
    input  logic                           i_msg_valid,
    input  logic                           i_msg_ready,
    input  logic                           i_msg_bit,
    input  logic                           i_msg_last,
    input  logic                           i_code_valid,
    input  logic                           i_code_ready,
    input  logic                           i_code_bit,
    input  logic                           i_is_parity,
    input  logic                           i_word_last,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ccse_pkg::*;

    typedef struct packed {
        logic code_bit;
        logic is_parity;
        logic word_last;
    } code_req_t;

    code_req_t        codeword_bits[$];
    logic [GEN_W-1:0] gen_low;
    logic [LEN_W-1:0] par_len;
    logic [GEN_W-1:0] parity_reg;

    // Shift one bit into the remainder, fold in the generator on a carry out
    function automatic void divide_step(input logic [LEN_W-1:0] len, input logic b);
        logic [GEN_W:0]   wide;
        logic [GEN_W-1:0] mask;
        logic             carry;
        if (len == 0) begin
            parity_reg = '0;
            return;
        end
        wide  = ({{GEN_W{1'b0}}, 1'b1} << len) - 1'b1;
        mask  = wide[GEN_W-1:0];
        carry = parity_reg[len - 1];
        parity_reg = {parity_reg[GEN_W-2:0], b} & mask;
        if (carry) begin
            parity_reg ^= gen_low & mask;
        end
    endfunction

    // Queue the codeword bits that one message request produces
    task automatic encode_request(input logic b, input logic last);
        logic [LEN_W-1:0] len;
        code_req_t        r;
        int               i;
        len = (int'(par_len) > MAX_PARITY) ? LEN_W'(MAX_PARITY) : par_len;
        r.code_bit  = b;
        r.is_parity = 1'b0;
        r.word_last = last && (len == 0);
        codeword_bits.push_back(r);
        divide_step(len, b);
        if (last) begin
            // flush with zeros, then emit the remainder high degree first
            for (i = 0; i < int'(len); i++) begin
                divide_step(len, 1'b0);
            end
            for (i = int'(len) - 1; i >= 0; i--) begin
                r.code_bit  = parity_reg[i];
                r.is_parity = 1'b1;
                r.word_last = (i == 0);
                codeword_bits.push_back(r);
            end
            parity_reg = '0;
        end
    endtask

    function automatic void compare_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Match one code request against the oldest prediction
    task automatic check_code();
        code_req_t want;
        if (codeword_bits.size() == 0) begin
            $error("code_bit mismatch: expected none, actual %0d", i_code_bit);
            o_fail_count++;
            return;
        end
        want = codeword_bits.pop_front();
        compare_field("code_bit", want.code_bit, i_code_bit);
        compare_field("is_parity", want.is_parity, i_is_parity);
        compare_field("word_last", want.word_last, i_word_last);
    endtask

    // Follow the channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gen_low    = GEN_RESET;
            par_len    = LEN_RESET;
            parity_reg = '0;
            codeword_bits.delete();
        end else begin
            if (i_code_valid && i_code_ready) begin
                check_code();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_GEN_POLY_LOW: gen_low = i_cfg_data;
                    REG_PARITY_LEN:   par_len = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_msg_valid && i_msg_ready) begin
                encode_request(i_msg_bit, i_msg_last);
            end
        end
        o_pending <= codeword_bits.size();
    end

endmodule

// File: tb/sv/cyclic_code_systematic_encoder_tb.sv
// Testbench top for the cyclic code systematic encoder: drives message,
// register and code-ready traffic and reports the verdict.
// Depends on ccse_pkg, cyclic_code_systematic_encoder and ccse_code_checker.
module cyclic_code_systematic_encoder_tb;
    import ccse_pkg::*;

    localparam int MAX_LEN       = 63;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 2 * MAX_LEN + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 110;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [GEN_W-1:0]     i_cfg_data   = '0;
    logic                 i_msg_valid  = 1'b0;
    logic                 i_msg_bit    = 1'b0;
    logic                 i_msg_last   = 1'b0;
    logic                 i_code_ready = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_msg_ready;
    logic                 o_code_valid;
    logic                 o_code_bit;
    logic                 o_is_parity;
    logic                 o_word_last;

    int fail_count;
    int pending;
    int cycle_cnt     = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_req_cnt  = 0;
    int hold_seen_cnt = 0;
    int hold_left     = 0;

    cyclic_code_systematic_encoder #(.MAX_PARITY(MAX_LEN)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_msg_valid  (i_msg_valid),
        .o_msg_ready  (o_msg_ready),
        .i_msg_bit    (i_msg_bit),
        .i_msg_last   (i_msg_last),
        .o_code_valid (o_code_valid),
        .i_code_ready (i_code_ready),
        .o_code_bit   (o_code_bit),
        .o_is_parity  (o_is_parity),
        .o_word_last  (o_word_last)
    );

    ccse_code_checker #(.MAX_PARITY(MAX_LEN)) code_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_msg_valid  (i_msg_valid),
        .i_msg_ready  (o_msg_ready),
        .i_msg_bit    (i_msg_bit),
        .i_msg_last   (i_msg_last),
        .i_code_valid (o_code_valid),
        .i_code_ready (i_code_ready),
        .i_code_bit   (o_code_bit),
        .i_is_parity  (o_is_parity),
        .i_word_last  (o_word_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    // Drive code ready: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seen_cnt != hold_req_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_code_ready <= 1'b0;
        end else begin
            i_code_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one message request, idling first at the sender rate
    task automatic push_bit(input logic b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_msg_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_msg_valid <= 1'b1;
        i_msg_bit   <= b;
        i_msg_last  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_msg_ready);
        @(negedge i_clk);
    endtask

    // Issue one register write; the caller drops valid afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [GEN_W-1:0] gen, input logic [LEN_W-1:0] len);
        write_reg(REG_GEN_POLY_LOW, gen);
        write_reg(REG_PARITY_LEN, GEN_W'(len));
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every predicted code bit has been taken
    task automatic wait_idle();
        i_msg_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int               p;
        int               i;
        int               sent;
        int               words;
        int               nbits;
        logic [63:0]      rnd;
        logic [LEN_W-1:0] len;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset generator 0xD1, degree 8
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);
        push_bit(1'b0, 1'b1);

        // Unused register index must leave the setup alone
        wait_idle();
        rnd = {$urandom, $urandom};
        write_reg(REG_SPARE, rnd[GEN_W-1:0]);
        i_cfg_valid <= 1'b0;
        push_bit(1'b1, 1'b1);

        // No parity: the message passes through alone
        wait_idle();
        rnd = {$urandom, $urandom};
        apply_config(rnd[GEN_W-1:0], '0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b1);

        // Widest generator, all coefficients set
        wait_idle();
        apply_config('1, LEN_W'(MAX_LEN));
        push_bit(1'b1, 1'b1);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b1);

        // Degree one, zero low coefficients
        wait_idle();
        apply_config('0, 6'd1);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);

        // Shrink the degree in the middle of a word
        wait_idle();
        rnd = {$urandom, $urandom};
        apply_config(rnd[GEN_W-1:0], 6'd8);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        wait_idle();
        write_reg(REG_PARITY_LEN, GEN_W'(3));
        i_cfg_valid <= 1'b0;
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);

        // Random words over four idling mixes
        for (p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            sent  = 0;
            words = 0;
            while (sent < PHASE_ITEMS) begin
                if (words % 6 == 0) begin
                    wait_idle();
                    rnd = {$urandom, $urandom};
                    case ($urandom_range(9))
                        0: len = '0;
                        1: len = LEN_W'(MAX_LEN);
                        default: len = LEN_W'($urandom_range(1, 12));
                    endcase
                    apply_config(rnd[GEN_W-1:0], len);
                end
                nbits = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                // block the receiver while a long word keeps coming
                if (p == 0 && words == 1) begin
                    hold_req_cnt++;
                    nbits = 40;
                end
                for (i = 0; i < nbits; i++) begin
                    push_bit(1'($urandom_range(1)), i == nbits - 1);
                end
                sent += nbits;
                words++;
            end
        end

        i_msg_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/ccse_pkg.sv
src/ccse_cell.sv
src/cyclic_code_systematic_encoder.sv
tb/sv/ccse_code_checker.sv
tb/sv/cyclic_code_systematic_encoder_tb.sv
